// ----- hw/rtl/mexp_pkg.sv -----
// Shared constants, state type and multiplier request/response types for modular exponentiation.
package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  // two extra magnitude bits for 2*acc + a, one sign bit
  localparam int SW    = WIDTH + 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_SQR,
    S_MUL,
    S_OUT
  } mexp_state_e;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] res;
  } mul_rsp_t;

endpackage

// ----- hw/rtl/mexp_in_if.sv -----
// Request channel: base and exponent with valid/ready.
interface mexp_in_if
  import mexp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

// ----- hw/rtl/mexp_out_if.sv -----
// Result channel: power with valid/ready.
interface mexp_out_if
  import mexp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

// ----- hw/rtl/modular_exponentiation.sv -----
// Top level: modulus register, sequencer, serial multiplier and result register.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    base, exponent
//   out_o    out  valid/ready    power
//   cfg      in   cfg_we_i       cfg_data_i -> modulus
//
// Every modular product runs through the shared bit-serial multiplier. An item needs
// one reduction plus WIDTH squarings and one multiply per set exponent bit. A modulus
// below two answers 0 without using the multiplier. Reset clears control and sets the
// modulus to 2; one request is in flight at a time, and the next is accepted while a
// finished result waits in the output register.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIDTH-1:0] cfg_data_i,
  mexp_in_if.sink          in_i,
  mexp_out_if.source       out_o
);

  logic [WIDTH-1:0] modulus_q;
  logic             out_valid_q;
  logic [WIDTH-1:0] power_q;
  logic             take, res_valid;
  logic [WIDTH-1:0] res;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= WIDTH'(2);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_data_i;
    end
  end

  assign take = ~out_valid_q | out_o.ready;

  mexp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_i   (modulus_q),
    .in_i        (in_i),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp)
  );

  mexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .modulus_i (modulus_q),
    .req_i     (mul_req),
    .rsp_o     (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      power_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.power = power_q;

endmodule

// ----- hw/rtl/mexp_mulmod.sv -----
// Bit-serial modular multiplier, one multiplier bit per cycle with interleaved reduction.
module mexp_mulmod
  import mexp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] modulus_i,
  input  mul_req_t         req_i,
  output mul_rsp_t         rsp_o
);

  logic                    prep_q, run_q, done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [WIDTH-1:0]        a_q, b_q, m_q, acc_q;
  logic signed [SW-1:0]    k1_q, k2_q, nm_q;

  logic                    bit_cur;
  logic signed [SW-1:0]    dbl, add0, add1, c0, c1, c2, sel;

  // candidates 2*acc (+a) minus 0, m or 2m; keep the largest subtraction that stays >= 0
  always_comb begin
    bit_cur = b_q[WIDTH-1];
    dbl     = $signed({2'b00, acc_q, 1'b0});
    add0    = bit_cur ? $signed({3'b000, a_q}) : '0;
    add1    = bit_cur ? k1_q : nm_q;
    c0      = dbl + add0;
    c1      = dbl + add1;
    c2      = dbl + k2_q;
    if (bit_cur && !c2[SW-1]) begin
      sel = c2;
    end else if (!c1[SW-1]) begin
      sel = c1;
    end else begin
      sel = c0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      prep_q <= req_i.start;
      if (prep_q) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(WIDTH - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
      m_q <= modulus_i;
    end else if (prep_q) begin
      k1_q  <= $signed({3'b000, a_q}) - $signed({3'b000, m_q});
      k2_q  <= $signed({3'b000, a_q}) - $signed({2'b00, m_q, 1'b0});
      nm_q  <= -$signed({3'b000, m_q});
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= sel[WIDTH-1:0];
      b_q   <= {b_q[WIDTH-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule

// ----- hw/rtl/mexp_seq.sv -----
// Square-and-multiply sequencer: base reduction, then exponent scan from the top bit.
module mexp_seq
  import mexp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] modulus_i,
  mexp_in_if.sink          in_i,
  input  logic             take_i,
  output logic             res_valid_o,
  output logic [WIDTH-1:0] res_o,
  output mul_req_t         mul_req_o,
  input  mul_rsp_t         mul_rsp_i
);

  mexp_state_e      state_q, state_d;
  logic [WIDTH-1:0] e_q, bred_q, r_q;
  logic [CNT_W-1:0] cnt_q;
  logic             m_small, in_acc, e_bit, last_bit;

  assign m_small  = ~|modulus_i[WIDTH-1:1];
  assign in_acc   = in_i.valid & in_i.ready;
  assign e_bit    = e_q[WIDTH-1];
  assign last_bit = (cnt_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_i.valid) state_d = m_small ? S_OUT : S_RED;
      S_RED:  if (mul_rsp_i.done) state_d = S_SQR;
      S_SQR: begin
        if (mul_rsp_i.done) begin
          if (e_bit)         state_d = S_MUL;
          else if (last_bit) state_d = S_OUT;
        end
      end
      S_MUL: begin
        if (mul_rsp_i.done) state_d = last_bit ? S_OUT : S_SQR;
      end
      S_OUT:  if (take_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready      = 1'b0;
    res_valid_o     = 1'b0;
    mul_req_o.start = 1'b0;
    mul_req_o.a     = mul_rsp_i.res;
    mul_req_o.b     = mul_rsp_i.res;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready      = 1'b1;
        mul_req_o.start = in_i.valid & ~m_small;
        mul_req_o.a     = WIDTH'(1);
        mul_req_o.b     = in_i.base;
      end
      S_RED: begin
        // running value starts at one: first square is 1*1
        mul_req_o.start = mul_rsp_i.done;
        mul_req_o.a     = WIDTH'(1);
        mul_req_o.b     = WIDTH'(1);
      end
      S_SQR: begin
        mul_req_o.start = mul_rsp_i.done & (e_bit | ~last_bit);
        mul_req_o.b     = e_bit ? bred_q : mul_rsp_i.res;
      end
      S_MUL: begin
        mul_req_o.start = mul_rsp_i.done & ~last_bit;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      e_q   <= in_i.exponent;
      cnt_q <= CNT_W'(WIDTH - 1);
      r_q   <= '0;
    end
    if (state_q == S_RED && mul_rsp_i.done) begin
      bred_q <= mul_rsp_i.res;
    end
    if (state_q == S_SQR && mul_rsp_i.done) begin
      r_q <= mul_rsp_i.res;
      if (!e_bit) begin
        e_q   <= {e_q[WIDTH-2:0], 1'b0};
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
    if (state_q == S_MUL && mul_rsp_i.done) begin
      r_q   <= mul_rsp_i.res;
      e_q   <= {e_q[WIDTH-2:0], 1'b0};
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  assign res_o = r_q;

endmodule

// ----- tb/mexp_checker.sv -----
`timescale 1ns / 100ps
// Checker: predicts base^exponent mod modulus per request and compares it on the result channel.
module mexp_checker
  import mexp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIDTH-1:0] cfg_data_i,
  mexp_in_if               req_i,
  mexp_out_if              rsp_i,
  input  logic             end_check_i,
  output int unsigned      error_count_o
);

  logic [WIDTH-1:0] modulus_q;
  logic [WIDTH-1:0] pending_powers[$];
  logic             leftovers_done;
  int unsigned      errors = 0;

  assign error_count_o = errors;

  // products kept at double width, so nothing overflows before the reduction
  function automatic logic [WIDTH-1:0] mod_pow(input logic [WIDTH-1:0] base,
                                               input logic [WIDTH-1:0] exponent,
                                               input logic [WIDTH-1:0] modulus);
    logic [2*WIDTH-1:0] m;
    logic [2*WIDTH-1:0] b;
    logic [2*WIDTH-1:0] acc;
    int                 i;
    if (modulus < 2) begin
      return '0;
    end
    m   = (2*WIDTH)'(modulus);
    b   = (2*WIDTH)'(base) % m;
    acc = (2*WIDTH)'(1);
    for (i = WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (exponent[i]) begin
        acc = (acc * b) % m;
      end
    end
    return acc[WIDTH-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WIDTH-1:0] want;
    if (!rst_ni) begin
      modulus_q      = 2;
      leftovers_done = 1'b0;
      pending_powers.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_powers.size() == 0) begin
          $error("power: expected none, got %0h", rsp_i.power);
          errors++;
        end else begin
          want = pending_powers.pop_front();
          if (rsp_i.power !== want) begin
            $error("power: expected %0h, got %0h", want, rsp_i.power);
            errors++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_powers = {pending_powers, mod_pow(req_i.base, req_i.exponent, modulus_q)};
      end
      if (cfg_we_i) begin
        modulus_q = cfg_data_i;
      end
      if (end_check_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (pending_powers.size() != 0) begin
          $error("power: %0d expected results never arrived", pending_powers.size());
          errors += pending_powers.size();
        end
      end
    end
  end

endmodule

// ----- tb/tb_modular_exponentiation.sv -----
`timescale 1ns / 100ps
// Testbench top: drives requests, modulus writes and result back-pressure, and gives the verdict.
module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 2300;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 22;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             cfg_we;
  logic [WIDTH-1:0] cfg_data;
  logic             end_check;
  logic             steady;
  logic [WIDTH-1:0] cur_modulus;
  int unsigned      requests_sent = 0;
  int unsigned      results_seen  = 0;
  int unsigned      error_count;

  mexp_in_if  req_if ();
  mexp_out_if rsp_if ();

  modular_exponentiation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  mexp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .end_check_i   (end_check),
    .error_count_o (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      results_seen <= results_seen + 1;
    end
  end

  // entered and left at a falling edge
  task automatic push_request(input logic [WIDTH-1:0] base, input logic [WIDTH-1:0] exponent);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.base     <= base;
    req_if.exponent <= exponent;
    do @(posedge clk_i); while (!req_if.ready);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    wait (results_seen == requests_sent);
    @(negedge clk_i);
  endtask

  task automatic write_modulus(input logic [WIDTH-1:0] value);
    cfg_we      <= 1'b1;
    cfg_data    <= value;
    cur_modulus  = value;
    @(negedge clk_i);
    cfg_we      <= 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("modular_exponentiation: mismatch");
    $finish;
  end

  initial begin
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    int               phase;
    int               k;
    steady          = 1'b0;
    end_check       = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    cur_modulus     = 2;
    req_if.valid    = 1'b0;
    req_if.base     = '0;
    req_if.exponent = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // modulus left at its reset value of two
    push_request(32'h0000_0000, 32'h0000_0000);
    push_request(32'hffff_ffff, 32'hffff_ffff);
    push_request(32'h0000_0003, 32'h0000_0001);
    push_request(32'h0000_0002, 32'h0000_0005);
    settle();

    // largest 32-bit prime
    write_modulus(32'hffff_fffb);
    push_request(32'h0000_0000, 32'h0000_0000);
    push_request(32'h0000_0000, 32'h0000_0007);
    push_request(32'hffff_ffff, 32'h0000_0001);
    push_request(32'hffff_fffb, 32'h0000_0003);
    push_request(32'hffff_fffa, 32'hffff_ffff);
    push_request(32'h1234_5678, 32'h0000_0000);
    push_request(32'h0000_0002, 32'hffff_ffff);
    push_request(32'h0000_0001, 32'h8000_0000);
    settle();

    write_modulus(32'hffff_ffff);
    push_request(32'hffff_ffff, 32'hffff_ffff);
    push_request(32'hffff_fffe, 32'h0000_0002);
    push_request(32'hdead_beef, 32'h0000_0001);
    settle();

    // moduli below two answer zero
    write_modulus(32'h0000_0001);
    push_request(32'h0000_0005, 32'h0000_0000);
    push_request(32'hffff_ffff, 32'hffff_ffff);
    settle();
    write_modulus(32'h0000_0000);
    push_request(32'h0000_0005, 32'h0000_0000);
    push_request(32'h0000_0007, 32'h0000_0009);
    settle();

    write_modulus(32'h0000_0003);
    push_request(32'h0000_0000, 32'h0000_0000);
    push_request(32'h0000_0002, 32'hffff_ffff);
    push_request(32'haaaa_aaaa, 32'h5555_5555);
    settle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0: write_modulus($urandom | 32'h8000_0000);
        1: write_modulus($urandom_range(2, 255));
        2: write_modulus(32'd65537);
        3: write_modulus(32'h7fff_ffff);
        4: write_modulus(32'hffff_fffb);
        5: write_modulus($urandom_range(0, 1));
        6: write_modulus(32'h8000_0000);
        default: write_modulus($urandom);
      endcase
      steady = (phase % 3 == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0: b = '0;
          1: b = cur_modulus - 1;
          2: b = cur_modulus;
          3: b = $urandom_range(0, 15);
          default: b = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0: e = '0;
          1: e = '1;
          2: e = $urandom_range(0, 31);
          3: e = 32'd1 << $urandom_range(0, 31);
          default: e = $urandom;
        endcase
        push_request(b, e);
      end
      settle();
    end
    steady = 1'b0;

    // catch any stray result after the last one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    end_check <= 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    if (error_count == 0) begin
      $display("modular_exponentiation: match");
    end else begin
      $display("modular_exponentiation: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_in_if.sv
hw/rtl/mexp_out_if.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/mexp_seq.sv
hw/rtl/modular_exponentiation.sv
tb/mexp_checker.sv
tb/tb_modular_exponentiation.sv
